[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Implication that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst, trig, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, trig, prop)
`endif
`endif

[rtl/kuz_pkg.sv]
package kuz_pkg;

   typedef logic [127:0] block_type;
   typedef logic [7:0] byte_type;

   localparam int NumRoundKeys = 10;
   localparam int NumFeistel = 32;
   localparam int KeyIdxW = 4;
   localparam int StepW = 6;

   localparam logic [1:0] CSR_KEY0 = 2'd0;
   localparam logic [1:0] CSR_KEY1 = 2'd1;
   localparam logic [1:0] CSR_KEY2 = 2'd2;
   localparam logic [1:0] CSR_KEY3 = 2'd3;

   // Round function selector for the shared unit.
   typedef enum logic [1:0] {
      OP_FWD = 2'd0,
      OP_INV = 2'd1
   } op_type;

   localparam byte_type SboxFwd [256] = '{
      8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
      8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
      8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
      8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
      8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
      8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
      8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
      8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
      8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
      8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
      8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
      8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
      8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
      8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
      8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
      8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
   };

   localparam byte_type SboxInv [256] = '{
      8'hA5,8'h2D,8'h32,8'h8F,8'h0E,8'h30,8'h38,8'hC0,8'h54,8'hE6,8'h9E,8'h39,8'h55,8'h7E,8'h52,8'h91,
      8'h64,8'h03,8'h57,8'h5A,8'h1C,8'h60,8'h07,8'h18,8'h21,8'h72,8'hA8,8'hD1,8'h29,8'hC6,8'hA4,8'h3F,
      8'hE0,8'h27,8'h8D,8'h0C,8'h82,8'hEA,8'hAE,8'hB4,8'h9A,8'h63,8'h49,8'hE5,8'h42,8'hE4,8'h15,8'hB7,
      8'hC8,8'h06,8'h70,8'h9D,8'h41,8'h75,8'h19,8'hC9,8'hAA,8'hFC,8'h4D,8'hBF,8'h2A,8'h73,8'h84,8'hD5,
      8'hC3,8'hAF,8'h2B,8'h86,8'hA7,8'hB1,8'hB2,8'h5B,8'h46,8'hD3,8'h9F,8'hFD,8'hD4,8'h0F,8'h9C,8'h2F,
      8'h9B,8'h43,8'hEF,8'hD9,8'h79,8'hB6,8'h53,8'h7F,8'hC1,8'hF0,8'h23,8'hE7,8'h25,8'h5E,8'hB5,8'h1E,
      8'hA2,8'hDF,8'hA6,8'hFE,8'hAC,8'h22,8'hF9,8'hE2,8'h4A,8'hBC,8'h35,8'hCA,8'hEE,8'h78,8'h05,8'h6B,
      8'h51,8'hE1,8'h59,8'hA3,8'hF2,8'h71,8'h56,8'h11,8'h6A,8'h89,8'h94,8'h65,8'h8C,8'hBB,8'h77,8'h3C,
      8'h7B,8'h28,8'hAB,8'hD2,8'h31,8'hDE,8'hC4,8'h5F,8'hCC,8'hCF,8'h76,8'h2C,8'hB8,8'hD8,8'h2E,8'h36,
      8'hDB,8'h69,8'hB3,8'h14,8'h95,8'hBE,8'h62,8'hA1,8'h3B,8'h16,8'h66,8'hE9,8'h5C,8'h6C,8'h6D,8'hAD,
      8'h37,8'h61,8'h4B,8'hB9,8'hE3,8'hBA,8'hF1,8'hA0,8'h85,8'h83,8'hDA,8'h47,8'hC5,8'hB0,8'h33,8'hFA,
      8'h96,8'h6F,8'h6E,8'hC2,8'hF6,8'h50,8'hFF,8'h5D,8'hA9,8'h8E,8'h17,8'h1B,8'h97,8'h7D,8'hEC,8'h58,
      8'hF7,8'h1F,8'hFB,8'h7C,8'h09,8'h0D,8'h7A,8'h67,8'h45,8'h87,8'hDC,8'hE8,8'h4F,8'h1D,8'h4E,8'h04,
      8'hEB,8'hF8,8'hF3,8'h3E,8'h3D,8'hBD,8'h8A,8'h88,8'hDD,8'hCD,8'h0B,8'h13,8'h98,8'h02,8'h93,8'h80,
      8'h90,8'hD0,8'h24,8'h34,8'hCB,8'hED,8'hF4,8'hCE,8'h99,8'h10,8'h44,8'h40,8'h92,8'h3A,8'h01,8'h26,
      8'h12,8'h1A,8'h48,8'h68,8'hF5,8'h81,8'h8B,8'hC7,8'hD6,8'h20,8'h0A,8'h08,8'h00,8'h4C,8'hD7,8'h74
   };

   // Coefficient of block byte i (byte 0 most significant) in the linear form.
   localparam byte_type LinCoef [16] = '{
      8'h94,8'h20,8'h85,8'h10,8'hC2,8'hC0,8'h01,8'hFB,
      8'h01,8'hC0,8'hC2,8'h10,8'h85,8'h20,8'h94,8'h01
   };

   // Multiply by a constant in GF(2^8) modulo x^8 + x^7 + x^6 + x + 1.
   function automatic byte_type gf_mul(input byte_type a, input byte_type b);
      byte_type acc;
      byte_type x;
      acc = '0;
      x = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) acc = acc ^ x;
         x = {x[6:0], 1'b0} ^ (x[7] ? 8'hC3 : 8'h00);
      end
      return acc;
   endfunction

   // Byte i of the block sits at bits [127-8i -: 8].
   function automatic byte_type get_byte(input block_type b, input int i);
      return b[127 - 8 * i -: 8];
   endfunction

   // One step of the forward linear register.
   function automatic block_type r_fwd(input block_type b);
      byte_type acc;
      acc = get_byte(b, 15);
      for (int i = 0; i < 15; i++) acc = acc ^ gf_mul(get_byte(b, i), LinCoef[i]);
      return {acc, b[127:8]};
   endfunction

   // One step of the inverse linear register.
   function automatic block_type r_inv(input block_type b);
      byte_type acc;
      block_type s;
      s = {b[119:0], 8'h00};
      acc = get_byte(b, 0);
      for (int i = 0; i < 15; i++) acc = acc ^ gf_mul(get_byte(s, i), LinCoef[i]);
      return {s[127:8], acc};
   endfunction

   function automatic block_type sub_fwd(input block_type b);
      block_type r;
      for (int i = 0; i < 16; i++) r[8 * i +: 8] = SboxFwd[b[8 * i +: 8]];
      return r;
   endfunction

   function automatic block_type sub_inv(input block_type b);
      block_type r;
      for (int i = 0; i < 16; i++) r[8 * i +: 8] = SboxInv[b[8 * i +: 8]];
      return r;
   endfunction

endpackage

[rtl/kuz_round.sv]
`include "assert_macros.svh"

// Shared round unit: S layer and L layer, forward or inverse, in one of
// four phases. The L layer is built from sixteen register steps that are
// applied four at a time, so one full round takes four phases.
module kuz_round (
   input  logic               clock,
   input  logic               reset,
   input  kuz_pkg::op_type    op,
   input  logic               apply_sub,
   input  kuz_pkg::block_type din,
   output kuz_pkg::block_type dout
);

   kuz_pkg::block_type pre;
   kuz_pkg::block_type acc;

   // Forward: S before L steps. Inverse: L steps, then inverse S, which the caller
   // selects through apply_sub on the final phase.
   always_comb begin
      pre = din;
      if (apply_sub && op == kuz_pkg::OP_FWD) pre = kuz_pkg::sub_fwd(din);
      acc = pre;
      for (int s = 0; s < 4; s++) begin
         if (op == kuz_pkg::OP_FWD) acc = kuz_pkg::r_fwd(acc);
         else acc = kuz_pkg::r_inv(acc);
      end
      dout = acc;
      if (apply_sub && op == kuz_pkg::OP_INV) dout = kuz_pkg::sub_inv(acc);
   end

   `ASSERT_ALWAYS(a_op_known, clock, reset,
      (op == kuz_pkg::OP_FWD) || (op == kuz_pkg::OP_INV))
   `ASSERT_ALWAYS(a_din_known, clock, reset, !$isunknown(din))
   `ASSERT_ALWAYS(a_zero_lin, clock, reset,
      apply_sub || (din != '0) || (dout == '0))

endmodule

[rtl/kuznyechik_block_cipher.sv]
// Kuznyechik block cipher, 128-bit block, 256-bit key.
// A block runs nine rounds of four phases, then one final key add, then the
// result strobe; a new block is taken only once the last one is through.
// A block that finds the round keys stale runs key expansion first.
// Synchronous active-high reset clears control state; key words reset to zero.
// The result is shown for one cycle on rsp_valid; the receiver cannot stall.
module kuznyechik_block_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_high,
   output logic [63:0] rsp_result_low,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXP  = 4'b0010,
      ST_RUN  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [63:0] key_ff [4];
   logic keys_ready_ff, keys_ready_in;
   logic kind_ff, kind_in;
   kuz_pkg::block_type blk_ff, blk_in;
   kuz_pkg::block_type tmp_ff, tmp_in;
   kuz_pkg::block_type hi_ff, hi_in, lo_ff, lo_in;
   logic [1:0] phase_ff, phase_in;
   logic half_ff, half_in;
   logic [kuz_pkg::StepW-1:0] step_ff, step_in;
   logic [kuz_pkg::KeyIdxW-1:0] rnd_ff, rnd_in;
   kuz_pkg::block_type rk_mem [kuz_pkg::NumRoundKeys];
   kuz_pkg::block_type rk_rd_ff;
   logic [kuz_pkg::KeyIdxW-1:0] rk_rd_addr;
   logic rk_we;
   logic [kuz_pkg::KeyIdxW-1:0] rk_wa;
   kuz_pkg::block_type rk_wd;
   kuz_pkg::op_type u_op;
   logic u_sub;
   kuz_pkg::block_type u_din, u_dout;
   kuz_pkg::block_type cvec;

   kuz_round u_round (
      .clock(clock), .reset(reset), .op(u_op), .apply_sub(u_sub),
      .din(u_din), .dout(u_dout)
   );

   // Feistel constant: the step count plus one in the last byte, before its L layer.
   assign cvec = 128'(step_ff) + 128'd1;

   // Key words.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
      end else if (csr_write) begin
         key_ff[csr_index] <= csr_data;
      end
   end

   // Round key memory, one write and one registered read port.
   always_ff @(posedge clock) begin
      if (rk_we) rk_mem[rk_wa] <= rk_wd;
      rk_rd_ff <= rk_mem[rk_rd_addr];
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      keys_ready_in = keys_ready_ff;
      kind_in = kind_ff;
      blk_in = blk_ff;
      tmp_in = tmp_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      phase_in = phase_ff;
      half_in = half_ff;
      step_in = step_ff;
      rnd_in = rnd_ff;
      rk_we = 1'b0;
      rk_wa = '0;
      rk_wd = '0;
      u_op = kuz_pkg::OP_FWD;
      u_sub = 1'b0;
      u_din = '0;
      rk_rd_addr = rnd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in = req_kind;
               blk_in = {req_block_high, req_block_low};
               phase_in = '0;
               half_in = 1'b0;
               step_in = '0;
               if (req_kind) rnd_in = kuz_pkg::KeyIdxW'(kuz_pkg::NumRoundKeys - 1);
               else rnd_in = '0;
               rk_rd_addr = rnd_in;
               if (!keys_ready_ff) begin
                  hi_in = {key_ff[0], key_ff[1]};
                  lo_in = {key_ff[2], key_ff[3]};
                  rk_we = 1'b1;
                  rk_wa = '0;
                  rk_wd = {key_ff[0], key_ff[1]};
                  state_in = ST_EXP;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_EXP: begin
            // First half runs L over the constant; second half runs S and L
            // over hi xor that constant. The input block waits in blk.
            if (!half_ff) u_din = (phase_ff == 2'd0) ? cvec : tmp_ff;
            else u_din = (phase_ff == 2'd0) ? (hi_ff ^ tmp_ff) : tmp_ff;
            u_sub = half_ff && (phase_ff == 2'd0);
            tmp_in = u_dout;
            phase_in = phase_ff + 2'd1;
            if (step_ff == kuz_pkg::StepW'(kuz_pkg::NumFeistel)) begin
               // The last key lands on phase 0; phase 1 reads the first round key.
               if (phase_ff == 2'd1) begin
                  keys_ready_in = 1'b1;
                  phase_in = '0;
                  state_in = ST_RUN;
               end
            end else if (phase_ff == 2'd3) begin
               half_in = !half_ff;
               if (half_ff) begin
                  hi_in = u_dout ^ lo_ff;
                  lo_in = hi_ff;
                  step_in = step_ff + kuz_pkg::StepW'(1);
                  if (step_ff[2:0] == 3'd7) begin
                     rk_we = 1'b1;
                     rk_wa = kuz_pkg::KeyIdxW'(step_ff[5:2]) + kuz_pkg::KeyIdxW'(1);
                     rk_wd = u_dout ^ lo_ff;
                  end
               end
            end
            // Write the odd key of each pair in the cycle after the even one.
            if (phase_ff == 2'd0 && !half_ff && step_ff[2:0] == 3'd0) begin
               rk_we = 1'b1;
               rk_wa = kuz_pkg::KeyIdxW'(step_ff[5:2]) + kuz_pkg::KeyIdxW'(1);
               rk_wd = lo_ff;
            end
         end
         ST_RUN: begin
            // Phase 0 adds the round key; encrypt S then L, decrypt L^-1 then S^-1.
            u_op = kind_ff ? kuz_pkg::OP_INV : kuz_pkg::OP_FWD;
            u_din = (phase_ff == 2'd0) ? (blk_ff ^ rk_rd_ff) : blk_ff;
            u_sub = kind_ff ? (phase_ff == 2'd3) : (phase_ff == 2'd0);
            blk_in = u_dout;
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               rnd_in = kind_ff ? rnd_ff - kuz_pkg::KeyIdxW'(1)
                                : rnd_ff + kuz_pkg::KeyIdxW'(1);
            end
            rk_rd_addr = rnd_in;
            if ((kind_ff && rnd_ff == '0 && phase_ff == 2'd0) ||
                (!kind_ff && rnd_ff == kuz_pkg::KeyIdxW'(kuz_pkg::NumRoundKeys - 1))) begin
               blk_in = blk_ff ^ rk_rd_ff;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_write) keys_ready_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         keys_ready_ff <= 1'b0;
         phase_ff <= '0;
         half_ff <= 1'b0;
         step_ff <= '0;
         rnd_ff <= '0;
      end else begin
         state_ff <= state_in;
         keys_ready_ff <= keys_ready_in;
         phase_ff <= phase_in;
         half_ff <= half_in;
         step_ff <= step_in;
         rnd_ff <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      blk_ff <= blk_in;
      tmp_ff <= tmp_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   // A new block is taken only in idle.
   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_result_high = blk_ff[127:64];
   assign rsp_result_low = blk_ff[63:0];

   `ASSERT_NEXT(a_done_one_cycle, clock, reset, state_ff == ST_DONE, state_ff == ST_IDLE)
   `ASSERT_ALWAYS(a_run_ready, clock, reset, (state_ff != ST_RUN) || keys_ready_ff || csr_write
      || $past(csr_write))
   `ASSERT_NEXT(a_exp_end, clock, reset,
      state_ff == ST_EXP && state_in == ST_RUN, keys_ready_ff || $past(csr_write))

endmodule
